// ===== rtl/foc_pkg.sv =====
// Shared constants, types and arithmetic helpers of the FOC current loop.
// No dependencies; used by every other file of the block.
package foc_pkg;

    localparam int SINE_DEPTH_DEF = 256;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int DATA_W     = 32;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 66;
    localparam int ANGLE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int GAIN_W     = 31;
    localparam int VLIM_W     = 25;

    localparam logic [63:0] INV_SQRT3_Q32 = 64'd2479700524;
    localparam logic [63:0] C099_Q32      = 64'd4252017623;
    localparam logic [63:0] TWO_PI_Q30    = 64'd6746518852;
    localparam logic [63:0] ONE_Q30       = 64'd1 << 30;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID_KP    = 3'd0,
        CFG_ID_KI    = 3'd1,
        CFG_IQ_KP    = 3'd2,
        CFG_IQ_KI    = 3'd3,
        CFG_VLIMIT   = 3'd4,
        CFG_AOFFSET  = 3'd5,
        CFG_REVERSE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic load;   // capture operands into the product register
    } t_mul_ctl;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res = v[DATA_W] ? S32_MIN : S32_MAX;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

    function automatic logic [DATA_W:0] mag33(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] ext;
        ext = {v[DATA_W-1], v};
        return v[DATA_W-1] ? DATA_W'(0) - ext : ext;
    endfunction

    // Floor quotient by restoring shift and subtract; elaboration only.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q, rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sine of a Q32 phase as a Q(frac) value; only evaluated at elaboration.
    function automatic logic signed [DATA_W-1:0] sin_phase(input logic [31:0] p,
                                                          input int frac);
        longint u;
        logic neg;
        longint unsigned mag, x, x2, t, s, dv;
        if (p < 32'h4000_0000) begin
            u = longint'(p);
        end else if (p < 32'hC000_0000) begin
            u = 64'sd2147483648 - longint'(p);
        end else begin
            u = longint'(p) - 64'sd4294967296;
        end
        neg = (u < 0);
        mag = neg ? longint'(-u) : longint'(u);
        x   = (mag * TWO_PI_Q30) >> 32;
        x2  = (x * x) >> 30;
        t   = ONE_Q30;
        for (int m = 7; m >= 1; m--) begin
            dv = longint'((2 * m) * (2 * m + 1));
            t  = ONE_Q30 - udiv64((x2 * t) >> 30, dv);
        end
        s = (x * t) >> 30;
        s = (s + (64'd1 << (29 - frac))) >> (30 - frac);
        return neg ? -DATA_W'(s) : DATA_W'(s);
    endfunction

endpackage

// ===== rtl/foc_mul.sv =====
// Shared signed multiplier with registered product and Q rounding/saturation.
// Depends on foc_pkg for widths and the saturation constants.
module foc_mul #(
    parameter int FRACTION_BITS = foc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  foc_pkg::t_mul_ctl                   i_ctl,
    input  logic signed [foc_pkg::OPND_W-1:0]   i_a,
    input  logic signed [foc_pkg::OPND_W-1:0]   i_b,
    output logic signed [foc_pkg::DATA_W-1:0]   o_rnd
);

    localparam logic signed [foc_pkg::PROD_W-1:0] HALF =
        foc_pkg::PROD_W'(1) <<< (FRACTION_BITS - 1);

    logic signed [foc_pkg::PROD_W-1:0] r_prod;
    logic signed [foc_pkg::PROD_W-1:0] w_sum;
    logic signed [foc_pkg::PROD_W-1:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= foc_pkg::PROD_W'(i_a) * foc_pkg::PROD_W'(i_b);
        end
    end

    assign w_sum = r_prod + HALF;
    assign w_sh  = w_sum >>> FRACTION_BITS;

    always_comb begin
        if (w_sh[foc_pkg::PROD_W-1:foc_pkg::DATA_W-1] == '0 ||
            w_sh[foc_pkg::PROD_W-1:foc_pkg::DATA_W-1] == '1) begin
            o_rnd = w_sh[foc_pkg::DATA_W-1:0];
        end else begin
            o_rnd = w_sh[foc_pkg::PROD_W-1] ? foc_pkg::S32_MIN : foc_pkg::S32_MAX;
        end
    end

endmodule

// ===== rtl/foc_current_loop.sv =====
// FOC current loop top level: config registers, sine table, sequencer, regulators.
// Depends on foc_pkg and foc_mul (the one shared multiplier).
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | command, currents, angle, iq target
//  out     | output    | o_out_valid / i_out_stall | v_alpha, v_beta, id/iq measured, running
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A run transaction takes 19 products through the shared multiplier, each through
// the operand, product, and round and write back states; S_DONE then hands the
// result to the output register; a stop transaction goes from idle straight to S_DONE.
// o_in_stall stays high until the result moves to the output register, which
// may still hold the previous result while the next transaction runs.
// Reset is synchronous, restores the config defaults and clears the filter, integrator and clamp state.
module foc_current_loop #(
    parameter int SINE_TABLE_DEPTH = foc_pkg::SINE_DEPTH_DEF,
    parameter int FRACTION_BITS    = foc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic signed [foc_pkg::DATA_W-1:0]     i_current_a,
    input  logic signed [foc_pkg::DATA_W-1:0]     i_current_b,
    input  logic [foc_pkg::ANGLE_W-1:0]           i_electrical_angle,
    input  logic signed [foc_pkg::DATA_W-1:0]     i_iq_reference,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [foc_pkg::DATA_W-1:0]     o_v_alpha,
    output logic signed [foc_pkg::DATA_W-1:0]     o_v_beta,
    output logic signed [foc_pkg::DATA_W-1:0]     o_id_measured,
    output logic signed [foc_pkg::DATA_W-1:0]     o_iq_measured,
    output logic                                  o_running,
    input  logic                                  i_cfg_we,
    input  logic [foc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [foc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DW = foc_pkg::DATA_W;
    localparam int OW = foc_pkg::OPND_W;
    localparam int KW = $clog2(SINE_TABLE_DEPTH);
    localparam logic [KW-1:0] QUARTER = KW'(SINE_TABLE_DEPTH / 4);

    localparam logic signed [OW-1:0] K_HALF = OW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [OW-1:0] K_INV3 = OW'(foc_pkg::INV_SQRT3_Q32 >> (32 - FRACTION_BITS));
    localparam logic signed [OW-1:0] K_C099 = OW'(foc_pkg::C099_Q32 >> (32 - FRACTION_BITS));

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_OPND = 5'b00010,
        S_MULT = 5'b00100,
        S_WRBK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        ST_NEG_A, ST_FILT_A, ST_NEG_B, ST_FILT_B, ST_BETA,
        ST_D_AC, ST_D_BS, ST_Q_BC, ST_Q_AS,
        ST_UI_D, ST_DEC_D, ST_RAW_D,
        ST_UI_Q, ST_DEC_Q, ST_RAW_Q,
        ST_VA_DC, ST_VA_QS, ST_VB_DS, ST_VB_QC
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [foc_pkg::GAIN_W-1:0]  r_kp_d, r_ki_d, r_kp_q, r_ki_q;
    logic [foc_pkg::VLIM_W-1:0]  r_vlim;
    logic [foc_pkg::ANGLE_W-1:0] r_aoff;
    logic                        r_rev;

    logic signed [OW-1:0] r_neg_a, r_neg_b, r_opa, r_opb;
    logic signed [DW-1:0] r_iqref, r_sin, r_cos;
    logic signed [DW-1:0] r_filt_a, r_filt_b, r_integ_d, r_integ_q;
    logic signed [DW-1:0] r_lo_d, r_lr_d, r_lo_q, r_lr_q;
    logic signed [DW-1:0] r_t0, r_beta, r_ds, r_qs, r_up, r_va, r_vb;
    logic                 r_flag, r_run, r_out_valid;
    logic signed [DW-1:0] r_o_va, r_o_vb, r_o_ds, r_o_qs;
    logic                 r_o_run;

    logic signed [DW-1:0] w_sin_tab [SINE_TABLE_DEPTH];
    logic [foc_pkg::ANGLE_W-1:0] w_ang_diff, w_ang;
    logic [KW-1:0]        w_k_sin, w_k_cos;
    logic signed [OW-1:0] w_opa, w_opb;
    logic signed [DW-1:0] w_rnd, w_lim, w_clamp;
    logic                 w_in_acc, w_out_free;
    foc_pkg::t_mul_ctl    w_mul_ctl;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sin
        localparam logic signed [DW-1:0] VAL =
            foc_pkg::sin_phase(32'(g) << (32 - KW), FRACTION_BITS);
        assign w_sin_tab[g] = VAL;
    end

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_ang_diff = i_electrical_angle - r_aoff;
    assign w_ang      = r_rev ? foc_pkg::ANGLE_W'(0) - w_ang_diff : w_ang_diff;
    assign w_k_sin    = w_ang[foc_pkg::ANGLE_W-1 -: KW];
    assign w_k_cos    = w_k_sin + QUARTER;

    assign w_lim   = DW'(r_vlim);
    assign w_clamp = (w_rnd > w_lim) ? w_lim : ((w_rnd < -w_lim) ? -w_lim : w_rnd);

    assign w_mul_ctl.load = (r_state == S_MULT);

    foc_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_ctl (w_mul_ctl),
        .i_a   (r_opa),
        .i_b   (r_opb),
        .o_rnd (w_rnd)
    );

    // Operand select per sequencer step
    always_comb begin
        w_opa = r_neg_a;
        w_opb = K_HALF;
        unique case (r_step)
            ST_NEG_A:  begin w_opa = r_neg_a;  w_opb = K_HALF; end
            ST_FILT_A: begin w_opa = OW'(r_filt_a); w_opb = K_HALF; end
            ST_NEG_B:  begin w_opa = r_neg_b;  w_opb = K_HALF; end
            ST_FILT_B: begin w_opa = OW'(r_filt_b); w_opb = K_HALF; end
            ST_BETA: begin
                w_opa = OW'(foc_pkg::sat_add(r_filt_a, foc_pkg::sat_add(r_filt_b, r_filt_b)));
                w_opb = K_INV3;
            end
            ST_D_AC:  begin w_opa = OW'(r_filt_a); w_opb = OW'(r_cos); end
            ST_D_BS:  begin w_opa = OW'(r_beta);   w_opb = OW'(r_sin); end
            ST_Q_BC:  begin w_opa = OW'(r_beta);   w_opb = OW'(r_cos); end
            ST_Q_AS:  begin w_opa = OW'(r_filt_a); w_opb = OW'(r_sin); end
            ST_UI_D: begin
                w_opa = OW'(r_ki_d);
                w_opb = OW'(foc_pkg::sat_sub('0, r_ds));
            end
            ST_DEC_D: begin w_opa = OW'(r_integ_d); w_opb = K_C099; end
            ST_RAW_D: begin
                w_opa = OW'(r_kp_d);
                w_opb = OW'(foc_pkg::sat_add(r_up, r_integ_d));
            end
            ST_UI_Q: begin
                w_opa = OW'(r_ki_q);
                w_opb = OW'(foc_pkg::sat_sub(r_iqref, r_qs));
            end
            ST_DEC_Q: begin w_opa = OW'(r_integ_q); w_opb = K_C099; end
            ST_RAW_Q: begin
                w_opa = OW'(r_kp_q);
                w_opb = OW'(foc_pkg::sat_add(r_up, r_integ_q));
            end
            ST_VA_DC: begin w_opa = OW'(r_lo_d); w_opb = OW'(r_cos); end
            ST_VA_QS: begin w_opa = OW'(r_lo_q); w_opb = OW'(r_sin); end
            ST_VB_DS: begin w_opa = OW'(r_lo_d); w_opb = OW'(r_sin); end
            ST_VB_QC: begin w_opa = OW'(r_lo_q); w_opb = OW'(r_cos); end
            default: begin w_opa = r_neg_a; w_opb = K_HALF; end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_d <= foc_pkg::GAIN_W'(16777216);
            r_ki_d <= '0;
            r_kp_q <= foc_pkg::GAIN_W'(16777216);
            r_ki_q <= '0;
            r_vlim <= foc_pkg::VLIM_W'(16609444);
            r_aoff <= '0;
            r_rev  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (foc_pkg::t_cfg_idx'(i_cfg_index))
                foc_pkg::CFG_ID_KP:   r_kp_d <= i_cfg_data;
                foc_pkg::CFG_ID_KI:   r_ki_d <= i_cfg_data;
                foc_pkg::CFG_IQ_KP:   r_kp_q <= i_cfg_data;
                foc_pkg::CFG_IQ_KI:   r_ki_q <= i_cfg_data;
                foc_pkg::CFG_VLIMIT:  r_vlim <= i_cfg_data[foc_pkg::VLIM_W-1:0];
                foc_pkg::CFG_AOFFSET: r_aoff <= i_cfg_data[foc_pkg::ANGLE_W-1:0];
                foc_pkg::CFG_REVERSE: r_rev  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_NEG_A;
            r_out_valid <= 1'b0;
            r_filt_a    <= '0;
            r_filt_b    <= '0;
            r_integ_d   <= '0;
            r_integ_q   <= '0;
            r_lo_d      <= '0;
            r_lr_d      <= '0;
            r_lo_q      <= '0;
            r_lr_q      <= '0;
            r_run       <= 1'b0;
        end else begin
            // Drop the output transaction once taken; in S_DONE the reload covers it
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_command) begin
                            r_neg_a <= -OW'(i_current_a);
                            r_neg_b <= -OW'(i_current_b);
                            r_iqref <= r_rev ? foc_pkg::sat_sub('0, i_iq_reference)
                                             : i_iq_reference;
                            r_sin   <= w_sin_tab[w_k_sin];
                            r_cos   <= w_sin_tab[w_k_cos];
                            r_run   <= 1'b1;
                            r_step  <= ST_NEG_A;
                            r_state <= S_OPND;
                        end else begin
                            r_integ_d <= '0;
                            r_integ_q <= '0;
                            r_lo_d    <= '0;
                            r_lo_q    <= '0;
                            r_va      <= '0;
                            r_vb      <= '0;
                            r_ds      <= '0;
                            r_qs      <= '0;
                            r_run     <= 1'b0;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_OPND: begin
                    r_opa <= w_opa;
                    r_opb <= w_opb;
                    if (r_step == ST_UI_D) begin
                        r_up <= foc_pkg::sat_sub('0, r_ds);
                    end
                    if (r_step == ST_UI_Q) begin
                        r_up <= foc_pkg::sat_sub(r_iqref, r_qs);
                    end
                    // Decay the integrator when the output clamped and it still grew
                    if (r_step == ST_DEC_D) begin
                        r_flag <= !(r_lo_d == r_lr_d ||
                                    foc_pkg::mag33(r_t0) < foc_pkg::mag33(r_integ_d));
                    end
                    if (r_step == ST_DEC_Q) begin
                        r_flag <= !(r_lo_q == r_lr_q ||
                                    foc_pkg::mag33(r_t0) < foc_pkg::mag33(r_integ_q));
                    end
                    r_state <= S_MULT;
                end
                S_MULT: begin
                    r_state <= S_WRBK;
                end
                S_WRBK: begin
                    unique case (r_step)
                        ST_FILT_A: r_filt_a <= foc_pkg::sat_add(r_t0, w_rnd);
                        ST_FILT_B: r_filt_b <= foc_pkg::sat_add(r_t0, w_rnd);
                        ST_BETA:   r_beta   <= w_rnd;
                        ST_D_BS:   r_ds     <= foc_pkg::sat_add(r_t0, w_rnd);
                        ST_Q_AS:   r_qs     <= foc_pkg::sat_sub(r_t0, w_rnd);
                        ST_UI_D:   r_t0     <= foc_pkg::sat_add(w_rnd, r_integ_d);
                        ST_DEC_D:  r_integ_d <= r_flag ? w_rnd : r_t0;
                        ST_RAW_D: begin
                            r_lr_d <= w_rnd;
                            r_lo_d <= w_clamp;
                        end
                        ST_UI_Q:   r_t0     <= foc_pkg::sat_add(w_rnd, r_integ_q);
                        ST_DEC_Q:  r_integ_q <= r_flag ? w_rnd : r_t0;
                        ST_RAW_Q: begin
                            r_lr_q <= w_rnd;
                            r_lo_q <= w_clamp;
                        end
                        ST_VA_QS:  r_va     <= foc_pkg::sat_sub(r_t0, w_rnd);
                        ST_VB_QC:  r_vb     <= foc_pkg::sat_add(r_t0, w_rnd);
                        default:   r_t0     <= w_rnd;
                    endcase
                    if (r_step == ST_VB_QC) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step  <= t_step'(r_step + 5'd1);
                        r_state <= S_OPND;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_o_va      <= r_va;
                        r_o_vb      <= r_vb;
                        r_o_ds      <= r_ds;
                        r_o_qs      <= r_qs;
                        r_o_run     <= r_run;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_v_alpha     = r_o_va;
    assign o_v_beta      = r_o_vb;
    assign o_id_measured = r_o_ds;
    assign o_iq_measured = r_o_qs;
    assign o_running     = r_o_run;

endmodule

// ===== rtl/foc_current_loop_chk.sv =====
// Port-level checker for the FOC current loop, bound to the top level.
// Depends on foc_pkg for port widths.
module foc_current_loop_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_command,
    input logic signed [foc_pkg::DATA_W-1:0] i_current_a,
    input logic signed [foc_pkg::DATA_W-1:0] i_current_b,
    input logic [foc_pkg::ANGLE_W-1:0]       i_electrical_angle,
    input logic signed [foc_pkg::DATA_W-1:0] i_iq_reference,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [foc_pkg::DATA_W-1:0] o_v_alpha,
    input logic signed [foc_pkg::DATA_W-1:0] o_v_beta,
    input logic signed [foc_pkg::DATA_W-1:0] o_id_measured,
    input logic signed [foc_pkg::DATA_W-1:0] o_iq_measured,
    input logic                              o_running,
    input logic                              i_cfg_we,
    input logic [foc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [foc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_v_alpha) &&
            $stable(o_v_beta) && $stable(o_running))
        else $error("stalled output transaction changed");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_running |-> o_v_alpha == 0 && o_v_beta == 0 &&
            o_id_measured == 0 && o_iq_measured == 0)
        else $error("stop result carries nonzero values");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again without processing");

    a_run_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command |=> ##2 !o_in_stall == 1'b0)
        else $error("run transaction finished too early");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind foc_current_loop foc_current_loop_chk u_foc_chk (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench of the FOC current loop: directed table, then random phases.
// Depends on foc_pkg and the foc_current_loop RTL; predicts each result in place unless a row fixes it.
`timescale 1ns / 100ps

module tb_top;

    localparam int  FB          = 24;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  NUM_PHASES  = 8;
    localparam int  PHASE_ITEMS = 225;
    localparam bit  CMD_STOP    = 1'b0;
    localparam bit  CMD_RUN     = 1'b1;
    localparam longint HALF_Q   = 64'sd1 << (FB - 1);
    localparam longint INV3_Q   = 64'sd2479700524 >>> (32 - FB);
    localparam longint DECAY_Q  = 64'sd4252017623 >>> (32 - FB);

    typedef struct {
        int va;
        int vb;
        int idm;
        int iqm;
        bit run;
    } t_drive;

    typedef struct {
        bit     cmd;
        int     cur_a;
        int     cur_b;
        bit [23:0] angle;
        int     iq_ref;
        bit     fixed;
        t_drive want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b0;
    logic signed [foc_pkg::DATA_W-1:0] i_current_a = '0;
    logic signed [foc_pkg::DATA_W-1:0] i_current_b = '0;
    logic [foc_pkg::ANGLE_W-1:0]       i_electrical_angle = '0;
    logic signed [foc_pkg::DATA_W-1:0] i_iq_reference = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [foc_pkg::DATA_W-1:0] o_v_alpha, o_v_beta, o_id_measured, o_iq_measured;
    logic        o_running;
    logic        i_cfg_we = 1'b0;
    logic [foc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [foc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    foc_current_loop DUT (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers and loop state
    longint kp_d, ki_d, kp_q, ki_q, vlimit;
    bit [23:0] aoffset;
    bit        rev;
    int filt_a, filt_b, integ_d, integ_q, out_d, raw_d, out_q, raw_q;

    t_drive pending[$];
    int     errors = 0;
    int     idle_cnt = 0;
    bit     quiet = 1'b0;

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic int qmul(longint a, longint b);
        return clip32((a * b + HALF_Q) >>> FB);
    endfunction

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Taylor sine of a Q32 turn phase, folded to a quarter turn
    function automatic int sine_q(bit [31:0] p);
        longint u;
        longint unsigned mag, x, x2, t, s;
        bit neg;
        if (p < 32'h4000_0000) u = longint'(p);
        else if (p < 32'hC000_0000) u = 64'sd2147483648 - longint'(p);
        else u = longint'(p) - 64'sd4294967296;
        neg = u < 0;
        mag = neg ? -u : u;
        x   = (mag * 64'd6746518852) >> 32;
        x2  = (x * x) >> 30;
        t   = 64'd1 << 30;
        for (int m = 7; m >= 1; m--)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((2 * m) * (2 * m + 1));
        s = (x * t) >> 30;
        s = (s + (64'd1 << (29 - FB))) >> (30 - FB);
        return neg ? -int'(s) : int'(s);
    endfunction

    function automatic int pi_step(int target, int fbk, longint kp, longint ki,
                                   ref int integ, ref int last_out, ref int last_raw);
        int up, ui, raw;
        up = clip32(longint'(target) - fbk);
        ui = clip32(longint'(qmul(ki, up)) + integ);
        // hold back the integrator while the output sits in the clamp
        if (!(last_out == last_raw || mag64(ui) < mag64(integ)))
            ui = qmul(integ, DECAY_Q);
        integ    = ui;
        raw      = qmul(kp, clip32(longint'(up) + ui));
        last_raw = raw;
        last_out = raw > vlimit ? int'(vlimit) : (raw < -vlimit ? -int'(vlimit) : raw);
        return last_out;
    endfunction

    function automatic t_drive predict_loop(bit cmd, int a, int b, bit [23:0] angle, int iq_ref);
        t_drive r;
        int alpha, beta, sn, cs, vd, vq, target;
        bit [23:0] ang;
        bit [31:0] ph;
        r = '{0, 0, 0, 0, 1'b0};
        if (cmd == CMD_STOP) begin
            integ_d = 0; integ_q = 0; out_d = 0; out_q = 0;
            return r;
        end
        filt_a = clip32(longint'(qmul(-longint'(a), HALF_Q)) + qmul(filt_a, HALF_Q));
        filt_b = clip32(longint'(qmul(-longint'(b), HALF_Q)) + qmul(filt_b, HALF_Q));
        alpha  = filt_a;
        beta   = qmul(clip32(longint'(filt_a) + clip32(2 * longint'(filt_b))), INV3_Q);
        ang = angle - aoffset;
        if (rev) ang = -ang;
        ph = {ang[23:16], 24'd0};
        sn = sine_q(ph);
        cs = sine_q(ph + 32'h4000_0000);
        r.idm  = clip32(longint'(qmul(alpha, cs)) + qmul(beta, sn));
        r.iqm  = clip32(longint'(qmul(beta, cs)) - qmul(alpha, sn));
        target = rev ? clip32(-longint'(iq_ref)) : iq_ref;
        vd = pi_step(0, r.idm, kp_d, ki_d, integ_d, out_d, raw_d);
        vq = pi_step(target, r.iqm, kp_q, ki_q, integ_q, out_q, raw_q);
        r.va  = clip32(longint'(qmul(vd, cs)) - qmul(vq, sn));
        r.vb  = clip32(longint'(qmul(vd, sn)) + qmul(vq, cs));
        r.run = 1'b1;
        return r;
    endfunction

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result va=%0d vb=%0d", $time, o_v_alpha, o_v_beta);
                errors++;
            end else begin
                t_drive w;
                w = pending.pop_front();
                if (o_v_alpha !== w.va || o_v_beta !== w.vb || o_id_measured !== w.idm ||
                    o_iq_measured !== w.iqm || o_running !== w.run) begin
                    $display("%0t: expected va=%0d vb=%0d id=%0d iq=%0d run=%0d", $time,
                             w.va, w.vb, w.idm, w.iqm, w.run);
                    $display("%0t: actual   va=%0d vb=%0d id=%0d iq=%0d run=%0d", $time,
                             o_v_alpha, o_v_beta, o_id_measured, o_iq_measured, o_running);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts, none once quiet
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    end

    task automatic write_reg(foc_pkg::t_cfg_idx idx, longint value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[foc_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            foc_pkg::CFG_ID_KP:   kp_d    = value & 64'h7FFF_FFFF;
            foc_pkg::CFG_ID_KI:   ki_d    = value & 64'h7FFF_FFFF;
            foc_pkg::CFG_IQ_KP:   kp_q    = value & 64'h7FFF_FFFF;
            foc_pkg::CFG_IQ_KI:   ki_q    = value & 64'h7FFF_FFFF;
            foc_pkg::CFG_VLIMIT:  vlimit  = value & 64'h1FF_FFFF;
            foc_pkg::CFG_AOFFSET: aoffset = value[23:0];
            foc_pkg::CFG_REVERSE: rev     = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic send(t_row row);
        t_drive got;
        @(negedge i_clk);
        i_in_valid         = 1'b1;
        i_command          = row.cmd;
        i_current_a        = row.cur_a;
        i_current_b        = row.cur_b;
        i_electrical_angle = row.angle;
        i_iq_reference     = row.iq_ref;
        do @(posedge i_clk); while (o_in_stall);
        got = predict_loop(row.cmd, row.cur_a, row.cur_b, row.angle, row.iq_ref);
        pending.push_back(row.fixed ? row.want : got);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_current();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return int'($urandom_range(0, 1 << 26)) - (1 << 25);
            default: return int'($urandom_range(0, 1 << 28)) - (1 << 27);
        endcase
    endfunction

    function automatic longint pick_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 64'h7FFF_FFFF;
            2: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(0, 4 << 24);
        endcase
    endfunction

    t_row rows[$];

    initial begin
        t_row row;
        kp_d = 1 << 24; ki_d = 0; kp_q = 1 << 24; ki_q = 0;
        vlimit = 16609444; aoffset = '0; rev = 1'b0;
        filt_a = 0; filt_b = 0; integ_d = 0; integ_q = 0;
        out_d = 0; raw_d = 0; out_q = 0; raw_q = 0;

        // directed table: fixed results only where they are obvious
        rows = '{
            '{CMD_STOP, 0, 0, 24'h0, 0, 1'b1, '{0, 0, 0, 0, 1'b0}},
            '{CMD_RUN,  0, 0, 24'h0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
            '{CMD_RUN,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  32'h8000_0000, 32'h8000_0000, 24'h0, 32'h8000_0000, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  32'h8000_0000, 32'h7FFF_FFFF, 24'h40_0000, 0, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  1 << 24, -(1 << 24), 24'h80_0000, 1 << 24, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  -(1 << 23), 1 << 22, 24'hC0_0000, -(1 << 24), 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  12345, -54321, 24'h00_FFFF, 7 << 20, 1'b0, '{0,0,0,0,0}},
            '{CMD_STOP, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF, 1'b1,
              '{0, 0, 0, 0, 1'b0}},
            '{CMD_RUN,  -1, -1, 24'h01_0000, -1, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  1, 1, 24'hFF_0000, 1, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555, 32'hAAAA_AAAA, 1'b0, '{0,0,0,0,0}},
            '{CMD_RUN,  32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA, 32'h5555_5555, 1'b0, '{0,0,0,0,0}}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send(rows[i]);
        drain();

        // replay the table with integral action, a tight clamp, reverse direction and an angle offset
        write_reg(foc_pkg::CFG_ID_KI, 1 << 23);
        write_reg(foc_pkg::CFG_IQ_KI, 1 << 23);
        write_reg(foc_pkg::CFG_VLIMIT, 1 << 22);
        write_reg(foc_pkg::CFG_REVERSE, 1);
        write_reg(foc_pkg::CFG_AOFFSET, 24'hFF_FFFF);
        foreach (rows[i]) begin
            row = rows[i];
            row.fixed = row.cmd == CMD_STOP;
            send(row);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph == NUM_PHASES - 1) quiet = 1'b1;
            write_reg(foc_pkg::CFG_ID_KP, ph == 0 ? 64'h7FFF_FFFF : pick_gain());
            write_reg(foc_pkg::CFG_ID_KI, ph == 0 ? 64'h7FFF_FFFF : (ph == 1 ? 0 : pick_gain()));
            write_reg(foc_pkg::CFG_IQ_KP, ph == 1 ? 0 : pick_gain());
            write_reg(foc_pkg::CFG_IQ_KI, ph == 1 ? 64'h7FFF_FFFF : pick_gain());
            write_reg(foc_pkg::CFG_VLIMIT,
                      ph == 0 ? 0 : (ph == 1 ? 1 << 24 : $urandom_range(0, 1 << 24)));
            write_reg(foc_pkg::CFG_AOFFSET, ph == 2 ? 0 : $urandom_range(0, 24'hFF_FFFF));
            write_reg(foc_pkg::CFG_REVERSE, ph % 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                row.cmd    = $urandom_range(0, 19) == 0 ? CMD_STOP : CMD_RUN;
                row.cur_a  = pick_current();
                row.cur_b  = pick_current();
                row.angle  = $urandom_range(0, 24'hFF_FFFF);
                row.iq_ref = pick_current();
                row.fixed  = 1'b0;
                send(row);
                // let the loop settle completely once, mid-way through phase 3
                if (ph == 3 && n == PHASE_ITEMS / 2) drain();
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/foc_pkg.sv
rtl/foc_mul.sv
rtl/foc_current_loop.sv
rtl/foc_current_loop_chk.sv
test/tb_top.sv
